// ----- rtl/core/shadow_band_clipper_defines.svh -----
// Assertion helpers for the shadow band clipper.
`ifndef SHADOW_BAND_CLIPPER_DEFINES_SVH
`define SHADOW_BAND_CLIPPER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sbc_pkg.sv -----
package sbc_pkg;

  localparam int NUM_BANDS   = 4;
  localparam int NUM_EDGES   = 4;
  localparam int BLUR_W      = 16;
  localparam int DROP_W      = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam int EDGE_L = 0;
  localparam int EDGE_T = 1;
  localparam int EDGE_R = 2;
  localparam int EDGE_B = 3;

  localparam logic [BLUR_W-1:0]        BLUR_RESET = 16'd32;
  localparam logic signed [DROP_W-1:0] DROP_RESET = 17'sd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_LEFT   = 3'd0,
    CFG_VIEW_TOP    = 3'd1,
    CFG_VIEW_RIGHT  = 3'd2,
    CFG_VIEW_BOTTOM = 3'd3,
    CFG_BLUR_SIZE   = 3'd4,
    CFG_DROP_OFFSET = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_BOTTOM = 2'd1,
    SIDE_LEFT   = 2'd2,
    SIDE_RIGHT  = 2'd3
  } side_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } q_status_t;

endpackage

// ----- rtl/core/sbc_front.sv -----
module sbc_front #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       in_img_left,
  input  logic signed [COORD_WIDTH-1:0]       in_img_top,
  input  logic signed [COORD_WIDTH-1:0]       in_img_right,
  input  logic signed [COORD_WIDTH-1:0]       in_img_bottom,
  input  logic signed [COORD_WIDTH-1:0]       view_left,
  input  logic signed [COORD_WIDTH-1:0]       view_top,
  input  logic signed [COORD_WIDTH-1:0]       view_right,
  input  logic signed [COORD_WIDTH-1:0]       view_bottom,
  input  logic [sbc_pkg::BLUR_W-1:0]          blur_size,
  input  logic signed [sbc_pkg::DROP_W-1:0]   drop_offset,
  input  sbc_pkg::q_status_t                  q_stat,
  output logic                                q_push,
  output logic [sbc_pkg::NUM_BANDS*sbc_pkg::NUM_EDGES*COORD_WIDTH+sbc_pkg::NUM_BANDS-1:0]
                                              q_wdata
);
  import sbc_pkg::*;

  localparam int MW = (COORD_WIDTH > DROP_W) ? COORD_WIDTH : DROP_W;
  localparam int EW = MW + 2;

  function automatic logic signed [EW-1:0] smax(input logic signed [EW-1:0] a,
                                                input logic signed [EW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [EW-1:0] smin(input logic signed [EW-1:0] a,
                                                input logic signed [EW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [EW-1:0] cext(input logic signed [COORD_WIDTH-1:0] v);
    return {{(EW-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  logic                  adv;
  logic signed [EW-1:0]  bl_ext, dr_ext;
  logic signed [EW-1:0]  img_nxt [NUM_EDGES];
  logic signed [EW-1:0]  sh_nxt  [NUM_EDGES];

  logic                  s1_valid_r;
  logic signed [EW-1:0]  s1_img_r [NUM_EDGES];
  logic signed [EW-1:0]  s1_sh_r  [NUM_EDGES];

  logic                  vp_ok, sh_ok;
  logic signed [EW-1:0]  mid_t, mid_b;
  logic signed [EW-1:0]  cand_nxt [NUM_BANDS][NUM_EDGES];
  logic [NUM_BANDS-1:0]  cand_ok_nxt;

  logic                  s2_valid_r;
  logic signed [EW-1:0]  s2_cand_r [NUM_BANDS][NUM_EDGES];
  logic [NUM_BANDS-1:0]  s2_ok_r;

  logic signed [EW-1:0]  vp_ext [NUM_EDGES];
  logic signed [EW-1:0]  clip   [NUM_BANDS][NUM_EDGES];
  logic [NUM_BANDS-1:0]  mask;

  // Stage 1: shadow rectangle.
  always_comb begin
    bl_ext = {{(EW-BLUR_W){1'b0}}, blur_size};
    dr_ext = {{(EW-DROP_W){drop_offset[DROP_W-1]}}, drop_offset};
    img_nxt[EDGE_L] = cext(in_img_left);
    img_nxt[EDGE_T] = cext(in_img_top);
    img_nxt[EDGE_R] = cext(in_img_right);
    img_nxt[EDGE_B] = cext(in_img_bottom);
    sh_nxt[EDGE_L] = img_nxt[EDGE_L] - bl_ext;
    sh_nxt[EDGE_T] = img_nxt[EDGE_T] - bl_ext + dr_ext;
    sh_nxt[EDGE_R] = img_nxt[EDGE_R] + bl_ext;
    sh_nxt[EDGE_B] = img_nxt[EDGE_B] + bl_ext + dr_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_img_r <= img_nxt;
      s1_sh_r  <= sh_nxt;
    end
  end

  // Stage 2: four candidate bands.
  always_comb begin
    vp_ok = (view_right > view_left) && (view_bottom > view_top);
    sh_ok = (s1_sh_r[EDGE_R] > s1_sh_r[EDGE_L]) && (s1_sh_r[EDGE_B] > s1_sh_r[EDGE_T]);
    mid_t = smax(s1_sh_r[EDGE_T], s1_img_r[EDGE_T]);
    mid_b = smin(s1_sh_r[EDGE_B], s1_img_r[EDGE_B]);

    cand_nxt[SIDE_TOP][EDGE_L] = s1_sh_r[EDGE_L];
    cand_nxt[SIDE_TOP][EDGE_T] = s1_sh_r[EDGE_T];
    cand_nxt[SIDE_TOP][EDGE_R] = s1_sh_r[EDGE_R];
    cand_nxt[SIDE_TOP][EDGE_B] = smin(s1_img_r[EDGE_T], s1_sh_r[EDGE_B]);

    cand_nxt[SIDE_BOTTOM][EDGE_L] = s1_sh_r[EDGE_L];
    cand_nxt[SIDE_BOTTOM][EDGE_T] = smax(s1_img_r[EDGE_B], s1_sh_r[EDGE_T]);
    cand_nxt[SIDE_BOTTOM][EDGE_R] = s1_sh_r[EDGE_R];
    cand_nxt[SIDE_BOTTOM][EDGE_B] = s1_sh_r[EDGE_B];

    cand_nxt[SIDE_LEFT][EDGE_L] = s1_sh_r[EDGE_L];
    cand_nxt[SIDE_LEFT][EDGE_T] = mid_t;
    cand_nxt[SIDE_LEFT][EDGE_R] = smin(s1_img_r[EDGE_L], s1_sh_r[EDGE_R]);
    cand_nxt[SIDE_LEFT][EDGE_B] = mid_b;

    cand_nxt[SIDE_RIGHT][EDGE_L] = smax(s1_img_r[EDGE_R], s1_sh_r[EDGE_L]);
    cand_nxt[SIDE_RIGHT][EDGE_T] = mid_t;
    cand_nxt[SIDE_RIGHT][EDGE_R] = s1_sh_r[EDGE_R];
    cand_nxt[SIDE_RIGHT][EDGE_B] = mid_b;

    for (int k = 0; k < NUM_BANDS; k++) begin
      cand_ok_nxt[k] = vp_ok && sh_ok &&
                       (cand_nxt[k][EDGE_R] > cand_nxt[k][EDGE_L]) &&
                       (cand_nxt[k][EDGE_B] > cand_nxt[k][EDGE_T]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cand_r <= cand_nxt;
      s2_ok_r   <= cand_ok_nxt;
    end
  end

  // Clip to the viewport and pack surviving bands.
  always_comb begin
    vp_ext[EDGE_L] = cext(view_left);
    vp_ext[EDGE_T] = cext(view_top);
    vp_ext[EDGE_R] = cext(view_right);
    vp_ext[EDGE_B] = cext(view_bottom);
    q_wdata = '0;
    for (int k = 0; k < NUM_BANDS; k++) begin
      clip[k][EDGE_L] = smax(s2_cand_r[k][EDGE_L], vp_ext[EDGE_L]);
      clip[k][EDGE_T] = smax(s2_cand_r[k][EDGE_T], vp_ext[EDGE_T]);
      clip[k][EDGE_R] = smin(s2_cand_r[k][EDGE_R], vp_ext[EDGE_R]);
      clip[k][EDGE_B] = smin(s2_cand_r[k][EDGE_B], vp_ext[EDGE_B]);
      mask[k] = s2_ok_r[k] &&
                (clip[k][EDGE_R] > clip[k][EDGE_L]) &&
                (clip[k][EDGE_B] > clip[k][EDGE_T]);
      for (int e = 0; e < NUM_EDGES; e++) begin
        q_wdata[NUM_BANDS + (k*NUM_EDGES + e)*COORD_WIDTH +: COORD_WIDTH] =
          clip[k][e][COORD_WIDTH-1:0];
      end
    end
    q_wdata[NUM_BANDS-1:0] = mask;
  end

  // Drop items with no surviving band; hold while the queue is full.
  assign adv      = !s2_valid_r || !(|mask) || q_stat.not_full;
  assign q_push   = s2_valid_r && (|mask) && q_stat.not_full;
  assign in_stall = !adv;

endmodule

// ----- rtl/core/sbc_queue.sv -----
module sbc_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [DATA_W-1:0]   wdata,
  input  logic                pop,
  output logic [DATA_W-1:0]   rdata,
  output sbc_pkg::q_status_t  stat
);
  import sbc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata          = mem_r[rd_ptr_r];
  assign stat.not_empty = (cnt_r != '0);
  assign stat.not_full  = (cnt_r != CNTW'(DEPTH));

endmodule

// ----- rtl/core/sbc_back.sv -----
module sbc_back #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sbc_pkg::q_status_t                  q_stat,
  input  logic [sbc_pkg::NUM_BANDS*sbc_pkg::NUM_EDGES*COORD_WIDTH+sbc_pkg::NUM_BANDS-1:0]
                                              q_rdata,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_WIDTH-1:0]       out_band_left,
  output logic signed [COORD_WIDTH-1:0]       out_band_top,
  output logic signed [COORD_WIDTH-1:0]       out_band_right,
  output logic signed [COORD_WIDTH-1:0]       out_band_bottom,
  output logic [1:0]                          out_band_side,
  output logic                                out_band_last
);
  import sbc_pkg::*;

  localparam int BOX_W = NUM_BANDS * NUM_EDGES * COORD_WIDTH;

  logic [NUM_BANDS-1:0]   cur_mask_r, cur_mask_nxt;
  logic [BOX_W-1:0]       cur_data_r;
  logic                   has_band, load, last;
  logic [1:0]             idx;
  logic [NUM_BANDS-1:0]   rest;

  logic                   out_valid_r, out_valid_nxt;
  logic [COORD_WIDTH-1:0] band_l_r, band_t_r, band_r_r, band_b_r;
  side_t                  side_r;
  logic                   last_r;

  always_comb begin
    idx = '0;
    for (int k = NUM_BANDS - 1; k >= 0; k--) begin
      if (cur_mask_r[k]) begin
        idx = 2'(k);
      end
    end
    rest     = cur_mask_r & ~(NUM_BANDS'(1) << idx);
    has_band = |cur_mask_r;
    last     = (rest == '0);
    load     = has_band && (!out_valid_r || !out_stall);
    q_pop    = q_stat.not_empty && (!has_band || (load && last));

    cur_mask_nxt = cur_mask_r;
    if (q_pop) begin
      cur_mask_nxt = q_rdata[NUM_BANDS-1:0];
    end else if (load) begin
      cur_mask_nxt = rest;
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_mask_r  <= cur_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_data_r <= q_rdata[NUM_BANDS +: BOX_W];
    end
    if (load) begin
      band_l_r <= cur_data_r[(int'(idx)*NUM_EDGES + EDGE_L)*COORD_WIDTH +: COORD_WIDTH];
      band_t_r <= cur_data_r[(int'(idx)*NUM_EDGES + EDGE_T)*COORD_WIDTH +: COORD_WIDTH];
      band_r_r <= cur_data_r[(int'(idx)*NUM_EDGES + EDGE_R)*COORD_WIDTH +: COORD_WIDTH];
      band_b_r <= cur_data_r[(int'(idx)*NUM_EDGES + EDGE_B)*COORD_WIDTH +: COORD_WIDTH];
      side_r   <= side_t'(idx);
      last_r   <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_band_left   = band_l_r;
  assign out_band_top    = band_t_r;
  assign out_band_right  = band_r_r;
  assign out_band_bottom = band_b_r;
  assign out_band_side   = side_r;
  assign out_band_last   = last_r;

endmodule

// ----- rtl/core/shadow_band_clipper.sv -----
// An accepted image crosses the stage 1 and 2 registers, the queue, and the
//   back end's item and output registers. One band per cycle when not stalled
//   and bands are queued; an image with no surviving band is never queued.
// A 4-entry queue between classifier and band emitter absorbs output stalls.
// Reset (rst_n low, synchronous): pipeline and queue emptied, viewport set to
//   zero, blur_size to 32 and drop_offset to 16.
`include "shadow_band_clipper_defines.svh"

module shadow_band_clipper #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       in_img_left,
  input  logic signed [COORD_WIDTH-1:0]       in_img_top,
  input  logic signed [COORD_WIDTH-1:0]       in_img_right,
  input  logic signed [COORD_WIDTH-1:0]       in_img_bottom,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_WIDTH-1:0]       out_band_left,
  output logic signed [COORD_WIDTH-1:0]       out_band_top,
  output logic signed [COORD_WIDTH-1:0]       out_band_right,
  output logic signed [COORD_WIDTH-1:0]       out_band_bottom,
  output logic [1:0]                          out_band_side,
  output logic                                out_band_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [((COORD_WIDTH > sbc_pkg::DROP_W) ? COORD_WIDTH : sbc_pkg::DROP_W)-1:0]
                                              cfg_wdata
);
  import sbc_pkg::*;

  localparam int QW = NUM_BANDS * NUM_EDGES * COORD_WIDTH + NUM_BANDS;

  logic signed [COORD_WIDTH-1:0] view_left_r, view_top_r, view_right_r, view_bottom_r;
  logic [BLUR_W-1:0]             blur_size_r;
  logic signed [DROP_W-1:0]      drop_offset_r;

  q_status_t      q_stat;
  logic           q_push, q_pop;
  logic [QW-1:0]  q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_left_r   <= '0;
      view_top_r    <= '0;
      view_right_r  <= '0;
      view_bottom_r <= '0;
      blur_size_r   <= BLUR_RESET;
      drop_offset_r <= DROP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VIEW_LEFT:   view_left_r   <= cfg_wdata[COORD_WIDTH-1:0];
        CFG_VIEW_TOP:    view_top_r    <= cfg_wdata[COORD_WIDTH-1:0];
        CFG_VIEW_RIGHT:  view_right_r  <= cfg_wdata[COORD_WIDTH-1:0];
        CFG_VIEW_BOTTOM: view_bottom_r <= cfg_wdata[COORD_WIDTH-1:0];
        CFG_BLUR_SIZE:   blur_size_r   <= cfg_wdata[BLUR_W-1:0];
        CFG_DROP_OFFSET: drop_offset_r <= cfg_wdata[DROP_W-1:0];
        default: ;
      endcase
    end
  end

  sbc_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_img_left   (in_img_left),
    .in_img_top    (in_img_top),
    .in_img_right  (in_img_right),
    .in_img_bottom (in_img_bottom),
    .view_left     (view_left_r),
    .view_top      (view_top_r),
    .view_right    (view_right_r),
    .view_bottom   (view_bottom_r),
    .blur_size     (blur_size_r),
    .drop_offset   (drop_offset_r),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  sbc_queue #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  sbc_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_band_left   (out_band_left),
    .out_band_top    (out_band_top),
    .out_band_right  (out_band_right),
    .out_band_bottom (out_band_bottom),
    .out_band_side   (out_band_side),
    .out_band_last   (out_band_last)
  );

  `SBC_ASSERT_IMP(a_no_overflow, clk, rst_n, q_push, q_stat.not_full, "push into full queue")
  `SBC_ASSERT_IMP(a_no_underflow, clk, rst_n, q_pop, q_stat.not_empty, "pop from empty queue")
  `SBC_ASSERT_IMP(a_band_in_view, clk, rst_n, out_valid, (out_band_left >= view_left_r) && (out_band_top >= view_top_r) && (out_band_right <= view_right_r) && (out_band_bottom <= view_bottom_r) && (out_band_right > out_band_left) && (out_band_bottom > out_band_top), "band outside viewport or empty")

endmodule

// ----- tb/sv/band_checker.sv -----
`timescale 1ns / 100ps

module band_checker #(
  parameter int COORD_WIDTH = 20,
  localparam int CFG_DW = (COORD_WIDTH > sbc_pkg::DROP_W) ? COORD_WIDTH : sbc_pkg::DROP_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_img_left,
  input  logic signed [COORD_WIDTH-1:0] in_img_top,
  input  logic signed [COORD_WIDTH-1:0] in_img_right,
  input  logic signed [COORD_WIDTH-1:0] in_img_bottom,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [COORD_WIDTH-1:0] out_band_left,
  input  logic signed [COORD_WIDTH-1:0] out_band_top,
  input  logic signed [COORD_WIDTH-1:0] out_band_right,
  input  logic signed [COORD_WIDTH-1:0] out_band_bottom,
  input  logic [1:0]                    out_band_side,
  input  logic                          out_band_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]             cfg_wdata,
  output int                            errors,
  output int                            pending,
  output int                            images_seen,
  output int                            bands_seen
);
  import sbc_pkg::*;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] left;
    logic signed [COORD_WIDTH-1:0] top;
    logic signed [COORD_WIDTH-1:0] right;
    logic signed [COORD_WIDTH-1:0] bottom;
    side_t                         side;
    logic                          last;
  } band_t;

  band_t expected_bands[$];

  logic signed [COORD_WIDTH-1:0] view_l, view_t, view_r, view_b;
  logic [BLUR_W-1:0]             blur_amt;
  logic signed [DROP_W-1:0]      drop_amt;

  function automatic longint lmax(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint lmin(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 40) $display("[%0t] band mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic predict_bands(input longint il, input longint it, input longint ir,
                               input longint ib);
    longint vl, vt, vr, vb, grow, shift;
    longint sl, st, sr, sb, mid_t, mid_b;
    longint cl[4], ct[4], cr[4], cb[4];
    longint kl, kt, kr, kb;
    band_t  found[$];
    band_t  bnd;
    vl = view_l;
    vt = view_t;
    vr = view_r;
    vb = view_b;
    grow = blur_amt;
    shift = drop_amt;
    if (!(vr > vl && vb > vt)) return;
    sl = il - grow;
    st = it - grow + shift;
    sr = ir + grow;
    sb = ib + grow + shift;
    if (!(sr > sl && sb > st)) return;
    mid_t = lmax(st, it);
    mid_b = lmin(sb, ib);
    cl[SIDE_TOP]    = sl;             ct[SIDE_TOP]    = st;
    cr[SIDE_TOP]    = sr;             cb[SIDE_TOP]    = lmin(it, sb);
    cl[SIDE_BOTTOM] = sl;             ct[SIDE_BOTTOM] = lmax(ib, st);
    cr[SIDE_BOTTOM] = sr;             cb[SIDE_BOTTOM] = sb;
    cl[SIDE_LEFT]   = sl;             ct[SIDE_LEFT]   = mid_t;
    cr[SIDE_LEFT]   = lmin(il, sr);   cb[SIDE_LEFT]   = mid_b;
    cl[SIDE_RIGHT]  = lmax(ir, sl);   ct[SIDE_RIGHT]  = mid_t;
    cr[SIDE_RIGHT]  = sr;             cb[SIDE_RIGHT]  = mid_b;
    for (int i = 0; i < NUM_BANDS; i++) begin
      if (cr[i] > cl[i] && cb[i] > ct[i]) begin
        kl = lmax(cl[i], vl);
        kt = lmax(ct[i], vt);
        kr = lmin(cr[i], vr);
        kb = lmin(cb[i], vb);
        if (kr > kl && kb > kt) begin
          bnd.left   = kl[COORD_WIDTH-1:0];
          bnd.top    = kt[COORD_WIDTH-1:0];
          bnd.right  = kr[COORD_WIDTH-1:0];
          bnd.bottom = kb[COORD_WIDTH-1:0];
          bnd.side   = side_t'(i);
          bnd.last   = 1'b0;
          found.push_back(bnd);
        end
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_bands.push_back(found[i]);
  endtask

  task automatic check_band();
    band_t want;
    if (expected_bands.size() == 0) begin
      report_mismatch($sformatf("band side %0d arrived with nothing pending", out_band_side));
      return;
    end
    want = expected_bands.pop_front();
    bands_seen++;
    if (out_band_left !== want.left || out_band_top !== want.top ||
        out_band_right !== want.right || out_band_bottom !== want.bottom ||
        out_band_side !== want.side || out_band_last !== want.last)
      report_mismatch($sformatf(
        "got side %0d last %0b (%0d,%0d,%0d,%0d), want side %0d last %0b (%0d,%0d,%0d,%0d)",
        out_band_side, out_band_last, out_band_left, out_band_top, out_band_right,
        out_band_bottom, want.side, want.last, want.left, want.top, want.right,
        want.bottom));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      view_l   = '0;
      view_t   = '0;
      view_r   = '0;
      view_b   = '0;
      blur_amt = BLUR_RESET;
      drop_amt = DROP_RESET;
      expected_bands.delete();
    end else begin
      if (out_valid && !out_stall) check_band();
      if (in_valid && !in_stall) begin
        images_seen++;
        predict_bands(in_img_left, in_img_top, in_img_right, in_img_bottom);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_VIEW_LEFT:   view_l = cfg_wdata[COORD_WIDTH-1:0];
          CFG_VIEW_TOP:    view_t = cfg_wdata[COORD_WIDTH-1:0];
          CFG_VIEW_RIGHT:  view_r = cfg_wdata[COORD_WIDTH-1:0];
          CFG_VIEW_BOTTOM: view_b = cfg_wdata[COORD_WIDTH-1:0];
          CFG_BLUR_SIZE:   blur_amt = cfg_wdata[BLUR_W-1:0];
          CFG_DROP_OFFSET: drop_amt = cfg_wdata[DROP_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= expected_bands.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import sbc_pkg::*;

  localparam int     CW          = 20;
  localparam int     CFG_DW      = (CW > DROP_W) ? CW : DROP_W;
  localparam int     LATENCY     = 4;
  localparam int     TAIL        = 3 * LATENCY;
  localparam int     HOLD_CYCLES = 120;
  localparam longint MIN_C       = -524288;
  localparam longint MAX_C       = 524287;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] in_img_left = '0;
  logic signed [CW-1:0] in_img_top = '0;
  logic signed [CW-1:0] in_img_right = '0;
  logic signed [CW-1:0] in_img_bottom = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW-1:0] out_band_left;
  logic signed [CW-1:0] out_band_top;
  logic signed [CW-1:0] out_band_right;
  logic signed [CW-1:0] out_band_bottom;
  logic [1:0]           out_band_side;
  logic                 out_band_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_VIEW_LEFT;
  logic [CFG_DW-1:0]    cfg_wdata = '0;

  int errors, pending, images_seen, bands_seen;

  longint cur_vl, cur_vt, cur_vr, cur_vb, cur_blur, cur_drop;
  int     burst_left = 1;
  int     setups = 0;
  int     hold_seq = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     stall_pct = 0;
  int     stall_run = 0;

  always #5 clk = ~clk;

  shadow_band_clipper #(.COORD_WIDTH(CW)) dut (.*);

  band_checker #(.COORD_WIDTH(CW)) u_band_checker (.*);

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 55;
          default: stall_pct = 85;
        endcase
        stall_run = $urandom_range(10, 60);
      end
      stall_run--;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic longint pick_in(input longint lo, input longint hi);
    if (hi <= lo) return lo;
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic longint fit(input longint v);
    return (v < MIN_C) ? MIN_C : (v > MAX_C) ? MAX_C : v;
  endfunction

  task automatic send_image(input longint l, input longint t, input longint r,
                            input longint b);
    in_valid      <= 1'b1;
    in_img_left   <= CW'(l);
    in_img_top    <= CW'(t);
    in_img_right  <= CW'(r);
    in_img_bottom <= CW'(b);
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
    end
  endtask

  task automatic wait_idle(input int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_config(input longint vl, input longint vt, input longint vr,
                            input longint vb, input longint blur, input longint drop);
    logic [CFG_DW-1:0] value [6];
    cfg_idx_t          idx;
    wait_idle(TAIL);
    cur_vl = vl;
    cur_vt = vt;
    cur_vr = vr;
    cur_vb = vb;
    cur_blur = blur;
    cur_drop = drop;
    setups++;
    value[CFG_VIEW_LEFT]   = CFG_DW'(vl);
    value[CFG_VIEW_TOP]    = CFG_DW'(vt);
    value[CFG_VIEW_RIGHT]  = CFG_DW'(vr);
    value[CFG_VIEW_BOTTOM] = CFG_DW'(vb);
    value[CFG_BLUR_SIZE]   = CFG_DW'(blur);
    value[CFG_DROP_OFFSET] = CFG_DW'(drop);
    idx = CFG_VIEW_LEFT;
    repeat (idx.num()) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= value[idx];
      do @(posedge clk); while (!cfg_ready);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_setup(input bit tame);
    int     pick;
    longint a, b, vl, vt, vr, vb, blur, drop;
    pick = tame ? 2 : $urandom_range(9);
    if (pick == 0) begin
      vl = MIN_C; vt = MIN_C; vr = MAX_C; vb = MAX_C;
    end else if (pick == 1) begin
      a = pick_in(MIN_C, MAX_C); b = pick_in(MIN_C, MAX_C);
      vl = (a < b) ? a : b; vr = (a < b) ? b : a;
      a = pick_in(MIN_C, MAX_C); b = pick_in(MIN_C, MAX_C);
      vt = (a < b) ? a : b; vb = (a < b) ? b : a;
    end else begin
      vl = pick_in(-4000, 4000); vr = vl + pick_in(16, 3000);
      vt = pick_in(-4000, 4000); vb = vt + pick_in(16, 3000);
      if (pick == 9) begin
        if ($urandom_range(1)) vr = vl - pick_in(0, 200);
        else vb = vt - pick_in(0, 200);
      end
    end
    blur = ($urandom_range(5) == 0) ? pick_in(0, 65535) : pick_in(0, 400);
    drop = ($urandom_range(5) == 0) ? pick_in(-65536, 65535) : pick_in(-300, 300);
    set_config(vl, vt, vr, vb, blur, drop);
  endtask

  task automatic send_random_image();
    int     mode;
    longint span, dy, w, h, l, t, r, b;
    mode = $urandom_range(15);
    if (mode == 0) begin
      send_image(pick_in(MIN_C, MAX_C), pick_in(MIN_C, MAX_C), pick_in(MIN_C, MAX_C),
                 pick_in(MIN_C, MAX_C));
      return;
    end
    span = cur_blur + 64;
    dy = (cur_drop < 0) ? -cur_drop : cur_drop;
    w = pick_in(1, 4 * span + ((cur_vr > cur_vl) ? (cur_vr - cur_vl) / 4 : 0));
    h = pick_in(1, 4 * span + ((cur_vb > cur_vt) ? (cur_vb - cur_vt) / 4 : 0));
    l = pick_in(cur_vl - w - span, cur_vr + span);
    t = pick_in(cur_vt - h - span - dy, cur_vb + span + dy);
    r = (mode == 1) ? l - pick_in(0, w) : l + w;
    b = (mode == 2) ? t - pick_in(0, h) : t + h;
    send_image(fit(l), fit(t), fit(r), fit(b));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur_vl = 0; cur_vt = 0; cur_vr = 0; cur_vb = 0; cur_blur = 32; cur_drop = 16;

    send_image(0, 0, 160, 160);
    send_image(MIN_C, MIN_C, MAX_C, MAX_C);

    set_config(MIN_C, MIN_C, MAX_C, MAX_C, 65535, 65535);
    send_image(MIN_C, MIN_C, MAX_C, MAX_C);
    send_image(MIN_C, MIN_C, MIN_C + 16, MIN_C + 16);
    send_image(MAX_C - 16, MAX_C - 16, MAX_C, MAX_C);
    send_image(100, 200, 50, 300);
    send_image(0, 0, 0, 0);

    set_config(MIN_C, MIN_C, MAX_C, MAX_C, 0, -65536);
    send_image(-320, -160, 320, 160);
    send_image(MIN_C, MAX_C - 16, MIN_C + 32, MAX_C);
    send_image(0, 0, 0, 0);
    send_image(50, 50, 40, 60);

    set_config(-1600, -1600, 1600, 1600, 0, 0);
    send_image(-800, -800, 800, 800);
    send_image(-3200, -3200, 3200, 3200);

    set_config(-1600, -1600, 1600, 1600, 48, 24);
    send_image(-320, -320, 320, 320);
    send_image(-1620, -100, -1500, 100);
    send_image(4000, 4000, 4200, 4200);

    set_config(1600, 0, 1600, 800, 32, 16);
    send_image(1500, 100, 1700, 300);
    set_config(0, 800, 1600, -800, 32, 16);
    send_image(100, -100, 300, 100);

    for (int phase = 0; phase < 8; phase++) begin
      random_setup(phase == 2 || phase == 5);
      for (int k = 0; k < 44; k++) begin
        if ((phase == 2 || phase == 5) && k == 4) hold_seq <= hold_seq + 1;
        if (phase % 2 == 1 && k == 22) wait_idle(0);
        send_random_image();
      end
    end

    wait_idle(TAIL);
    $display("Covered %0d images and %0d bands over %0d register settings,",
             images_seen, bands_seen, setups);
    $display("with random stalls, long output hold-offs and full drains.");
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- shadow_band_clipper.f -----
+incdir+rtl/core
rtl/core/sbc_pkg.sv
rtl/core/sbc_front.sv
rtl/core/sbc_queue.sv
rtl/core/sbc_back.sv
rtl/core/shadow_band_clipper.sv
tb/sv/band_checker.sv
tb/sv/testbench.sv
